// ===== hdl/bnb_pkg.sv =====
package bnb_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned DepthBiasLsb = 66;

  localparam logic [1:0] ActPush  = 2'd0;
  localparam logic [1:0] ActPop   = 2'd1;
  localparam logic [1:0] ActPrune = 2'd2;
  localparam logic [1:0] ActNop   = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic [1:0] KindValue   = 2'd0;
  localparam logic [1:0] KindUnknown = 2'd1;
  localparam logic [1:0] KindEmpty   = 2'd2;

  localparam logic [1:0] PolBest  = 2'd0;
  localparam logic [1:0] PolDepth = 2'd1;
  localparam logic [1:0] PolEst   = 2'd2;
  localparam logic [1:0] PolBias  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] node_bound;
    logic               node_bound_unknown;
    logic signed [31:0] node_estimate;
    logic               node_estimate_valid;
    logic [15:0]        node_depth;
    logic signed [31:0] prune_cutoff;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_id;
    logic signed [31:0] out_bound;
    logic               out_bound_unknown;
    logic signed [31:0] out_estimate;
    logic               out_estimate_valid;
    logic [15:0]        out_depth;
    logic [6:0]         pruned_count;
    logic [6:0]         occupancy;
    logic signed [31:0] min_bound;
    logic [1:0]         min_bound_kind;
  } out_item_t;

  // one stored node
  typedef struct packed {
    logic signed [31:0] bound;
    logic               bound_unknown;
    logic signed [31:0] estimate;
    logic               estimate_valid;
    logic [15:0]        depth;
    logic [31:0]        id;
  } node_t;

  // pop ordering key prepared for a node, compared field by field
  typedef struct packed {
    logic               u1;
    logic signed [49:0] k1;
    logic               u2;
    logic signed [49:0] k2;
    logic [31:0]        id;
  } key_t;

endpackage

// ===== hdl/bnb_node_ram.sv =====
module bnb_node_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [bnb_pkg::SlotW-1:0] waddr_i,
  input  bnb_pkg::node_t            wdata_i,
  input  logic [bnb_pkg::SlotW-1:0] raddr_i,
  output bnb_pkg::node_t            rdata_o
);

  bnb_pkg::node_t mem [bnb_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/bnb_key_calc.sv =====
module bnb_key_calc (
  input  logic [1:0]     policy_i,
  input  bnb_pkg::node_t node_i,
  output bnb_pkg::key_t  key_o
);

  logic signed [49:0] bnd;
  logic signed [49:0] dep;
  logic signed [49:0] biased;

  always_comb begin
    bnd    = 50'(node_i.bound);
    dep    = 50'(node_i.depth);
    biased = bnd - dep * 50'(bnb_pkg::DepthBiasLsb);
    key_o  = '0;
    key_o.id = node_i.id;
    case (policy_i)
      bnb_pkg::PolBest: begin
        key_o.u1 = node_i.bound_unknown;
        key_o.k1 = bnd;
        key_o.k2 = -dep;
      end
      bnb_pkg::PolDepth: begin
        key_o.k1 = -dep;
        key_o.u2 = node_i.bound_unknown;
        key_o.k2 = bnd;
      end
      bnb_pkg::PolEst: begin
        key_o.u1 = node_i.estimate_valid ? 1'b0 : node_i.bound_unknown;
        key_o.k1 = node_i.estimate_valid ? 50'(node_i.estimate) : bnd;
        key_o.k2 = -dep;
      end
      default: begin
        key_o.u1 = node_i.bound_unknown;
        key_o.k1 = biased;
        key_o.u2 = node_i.bound_unknown;
        key_o.k2 = bnd;
      end
    endcase
    // unknown keys compare equal among themselves
    if (key_o.u1) key_o.k1 = '0;
    if (key_o.u2) key_o.k2 = '0;
  end

endmodule

// ===== hdl/bnb_node_priority_store.sv =====
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-------------------
// input    | in_valid_i  | in_stall_o  | in_item_i
// output   | out_valid_o | out_stall_i | out_item_o
// config   | cfg_we_i    | -           | cfg_data_i
// an input transfer is taken only while idle; a push writes the node memory at that edge
// every action then sweeps all 64 slots, one read a cycle: the node memory registers each read,
// the scan compares the read data, and the done state registers the result
// the next input transfers together with the waiting result;
// a stalled result holds off the input
// reset clears the slot used bits, count, id counter and policy; node memory data is only
// used for slots whose used bit is set
module bnb_node_priority_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bnb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bnb_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [1:0]                   policy_q;
  logic [bnb_pkg::Capacity-1:0] used_q, used_d;
  logic [bnb_pkg::CountW-1:0]   count_q, count_d;
  logic [31:0]                  next_id_q, next_id_d;
  bnb_pkg::in_item_t            item_q;
  logic [bnb_pkg::CountW-1:0]   raddr_q, raddr_d;   // read address sweep
  logic [bnb_pkg::SlotW-1:0]    rslot_q;            // slot of rdata
  logic                         rvld_q, rvld_d;
  logic                         best_vld_q, best_vld_d;
  logic [bnb_pkg::SlotW-1:0]    best_slot_q, best_slot_d;
  bnb_pkg::node_t               best_node_q, best_node_d;
  bnb_pkg::key_t                best_key_q, best_key_d;
  // two lowest known bounds, so a pop can take one of them away
  logic                         mn1_vld_q, mn1_vld_d;
  logic signed [31:0]           mn1_q, mn1_d;
  logic [bnb_pkg::SlotW-1:0]    mn1_slot_q, mn1_slot_d;
  logic                         mn2_vld_q, mn2_vld_d;
  logic signed [31:0]           mn2_q, mn2_d;
  logic [bnb_pkg::CountW-1:0]   pruned_q, pruned_d;
  bnb_pkg::out_item_t           res_q, res_d;       // push part of the result
  logic                         out_vld_q, out_vld_d;
  bnb_pkg::out_item_t           out_q, out_d;

  logic                         ram_we;
  bnb_pkg::node_t               ram_wdata, rdata;
  bnb_pkg::key_t                cur_key;
  logic                         better;
  logic                         take_in, scan_last, free_vld;
  logic [bnb_pkg::SlotW-1:0]    free_slot;
  logic                         keep;
  logic                         min_vld;
  logic signed [31:0]           min_val;

  bnb_node_ram u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (free_slot),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_q[bnb_pkg::SlotW-1:0]),
    .rdata_o (rdata)
  );

  bnb_key_calc u_key (
    .policy_i (policy_q),
    .node_i   (rdata),
    .key_o    (cur_key)
  );

  // lexicographic compare, strict
  always_comb begin
    if (cur_key.u1 != best_key_q.u1)      better = best_key_q.u1;
    else if (cur_key.k1 != best_key_q.k1) better = cur_key.k1 < best_key_q.k1;
    else if (cur_key.u2 != best_key_q.u2) better = best_key_q.u2;
    else if (cur_key.k2 != best_key_q.k2) better = cur_key.k2 < best_key_q.k2;
    else                                  better = cur_key.id < best_key_q.id;
  end

  // lowest free slot, priority search over the used bits
  always_comb begin
    free_vld  = 1'b0;
    free_slot = '0;
    for (int i = bnb_pkg::Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_vld  = 1'b1;
        free_slot = bnb_pkg::SlotW'(i);
      end
    end
  end

  assign in_stall_o  = (state_q != StIdle) || (out_vld_q && out_stall_i);
  assign take_in     = in_valid_i && !in_stall_o;
  assign scan_last   = rvld_q && (rslot_q == bnb_pkg::SlotW'(bnb_pkg::Capacity - 1));
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    count_d     = count_q;
    next_id_d   = next_id_q;
    raddr_d     = raddr_q;
    rvld_d      = 1'b0;
    best_vld_d  = best_vld_q;
    best_slot_d = best_slot_q;
    best_node_d = best_node_q;
    best_key_d  = best_key_q;
    mn1_vld_d   = mn1_vld_q;
    mn1_d       = mn1_q;
    mn1_slot_d  = mn1_slot_q;
    mn2_vld_d   = mn2_vld_q;
    mn2_d       = mn2_q;
    pruned_d    = pruned_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    keep        = 1'b1;
    min_vld     = 1'b0;
    min_val     = '0;
    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (take_in) begin
          state_d    = StScan;
          raddr_d    = '0;
          best_vld_d = 1'b0;
          mn1_vld_d  = 1'b0;
          mn2_vld_d  = 1'b0;
          pruned_d   = '0;
          res_d      = '0;
          if (in_item_i.action == bnb_pkg::ActPush) begin
            if (free_vld) begin
              ram_we    = 1'b1;
              ram_wdata = '{bound: in_item_i.node_bound,
                            bound_unknown: in_item_i.node_bound_unknown,
                            estimate: in_item_i.node_estimate,
                            estimate_valid: in_item_i.node_estimate_valid,
                            depth: in_item_i.node_depth, id: next_id_q};
              used_d[free_slot] = 1'b1;
              count_d      = count_q + bnb_pkg::CountW'(1);
              res_d.out_id = next_id_q;
              next_id_d    = next_id_q + 32'd1;
            end else begin
              res_d.status = bnb_pkg::StFull;
            end
          end
        end
      end
      StScan: begin
        if (raddr_q < bnb_pkg::CountW'(bnb_pkg::Capacity)) begin
          raddr_d = raddr_q + bnb_pkg::CountW'(1);
          rvld_d  = 1'b1;
        end
        if (rvld_q && used_q[rslot_q]) begin
          if (item_q.action == bnb_pkg::ActPrune && !rdata.bound_unknown
              && rdata.bound >= item_q.prune_cutoff) begin
            keep = 1'b0;
            used_d[rslot_q] = 1'b0;
            pruned_d = pruned_q + bnb_pkg::CountW'(1);
            count_d  = count_q - bnb_pkg::CountW'(1);
          end
          if (item_q.action == bnb_pkg::ActPop && (!best_vld_q || better)) begin
            best_vld_d  = 1'b1;
            best_slot_d = rslot_q;
            best_node_d = rdata;
            best_key_d  = cur_key;
          end
          if (keep && !rdata.bound_unknown) begin
            if (!mn1_vld_q || rdata.bound < mn1_q) begin
              mn2_vld_d  = mn1_vld_q;
              mn2_d      = mn1_q;
              mn1_vld_d  = 1'b1;
              mn1_d      = rdata.bound;
              mn1_slot_d = rslot_q;
            end else if (!mn2_vld_q || rdata.bound < mn2_q) begin
              mn2_vld_d = 1'b1;
              mn2_d     = rdata.bound;
            end
          end
        end
        if (scan_last) state_d = StDone;
      end
      StDone: begin
        out_d   = res_q;
        min_vld = mn1_vld_q;
        min_val = mn1_q;
        if (item_q.action == bnb_pkg::ActPop) begin
          if (best_vld_q) begin
            used_d[best_slot_q] = 1'b0;
            count_d = count_q - bnb_pkg::CountW'(1);
            out_d.out_id             = best_node_q.id;
            out_d.out_bound          = best_node_q.bound;
            out_d.out_bound_unknown  = best_node_q.bound_unknown;
            out_d.out_estimate       = best_node_q.estimate;
            out_d.out_estimate_valid = best_node_q.estimate_valid;
            out_d.out_depth          = best_node_q.depth;
            // popped node held the lowest bound, fall back to the runner-up
            if (mn1_vld_q && mn1_slot_q == best_slot_q) begin
              min_vld = mn2_vld_q;
              min_val = mn2_q;
            end
          end else begin
            out_d.status = bnb_pkg::StEmpty;
          end
        end
        out_d.pruned_count = 7'(pruned_q);
        out_d.occupancy    = 7'(count_d);
        if (min_vld) begin
          out_d.min_bound_kind = bnb_pkg::KindValue;
          out_d.min_bound      = min_val;
        end else if (count_d != '0) begin
          out_d.min_bound_kind = bnb_pkg::KindUnknown;
          out_d.min_bound      = 32'sd0;
        end else begin
          out_d.min_bound_kind = bnb_pkg::KindEmpty;
          out_d.min_bound      = 32'sh7FFFFFFF;
        end
        out_vld_d = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      policy_q  <= '0;
      used_q    <= '0;
      count_q   <= '0;
      next_id_q <= '0;
      raddr_q   <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_data_i;
      state_q   <= state_d;
      used_q    <= used_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      raddr_q   <= raddr_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) item_q <= in_item_i;
    rslot_q     <= raddr_q[bnb_pkg::SlotW-1:0];
    best_vld_q  <= best_vld_d;
    best_slot_q <= best_slot_d;
    best_node_q <= best_node_d;
    best_key_q  <= best_key_d;
    mn1_vld_q   <= mn1_vld_d;
    mn1_q       <= mn1_d;
    mn1_slot_q  <= mn1_slot_d;
    mn2_vld_q   <= mn2_vld_d;
    mn2_q       <= mn2_d;
    pruned_q    <= pruned_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> $stable(out_q)) else $error("stalled result changed");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> in_stall_o) else $error("input taken while busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == bnb_pkg::CountW'($countones(used_q))) else $error("count mismatch");

endmodule
